>>> design/esba_pkg.sv
// Shared types and constants for the exact-size block allocator.
package esba_pkg;

  localparam int MaxUnits = 1024;
  localparam int IdxW = $clog2(MaxUnits);
  localparam int SizeW = 11;
  localparam int OwnW = 10;
  localparam int AddrW = 11;

  typedef struct packed {
    logic mode;
    logic [SizeW-1:0] request_size;
    logic [OwnW-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic signed [AddrW-1:0] block_address;
    logic [SizeW-1:0] freed_units;
  } rsp_t;

  // One block descriptor as stored in the table.
  typedef struct packed {
    logic [IdxW-1:0] start;
    logic [SizeW-1:0] length;
    logic [OwnW-1:0] owner;
    logic in_use;
  } desc_t;

  localparam int DescW = $bits(desc_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CARVE,
    ST_DONE
  } state_t;

  localparam logic [0:0] MODE_ALLOC = 1'b0;
  localparam logic [0:0] ADDR_TOTAL_UNITS = 1'b0;
  localparam logic signed [AddrW-1:0] NO_ROOM = '1;

endpackage

>>> design/esba_desc_ram.sv
// Block descriptor table: one write port, one registered read port.
module esba_desc_ram
  import esba_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IdxW-1:0]  waddr,
  input  desc_t            wdata,
  input  logic [IdxW-1:0]  raddr,
  output desc_t            rdata
);

  desc_t mem [MaxUnits];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/exact_size_block_allocator.sv
// Top level: allocator control, scan sequencer and configuration port.
//
//   channel | direction | handshake       | payload
//   req     | in        | req_valid/stall | req_t (mode, request_size, owner_id)
//   rsp     | out       | rsp_valid/stall | rsp_t (block_address, freed_units)
//   apb     | in        | psel/penable    | total_units at address 0
//
// Each descriptor is read from the table, which has one write and one
// registered read port, then checked and possibly written back. Allocate
// stops at the first reusable block. One request is in work at a time.
// Reset clears the count and bump pointer; the table needs no clearing.
// A stalled result holds in the output register while the next request
// is already accepted.
module exact_size_block_allocator
  import esba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;
  req_t cur;
  logic [SizeW-1:0] total_units;
  logic [SizeW-1:0] block_count;
  logic [SizeW-1:0] bump_pointer;
  logic [IdxW-1:0] idx;
  logic [SizeW-1:0] sum;
  rsp_t result;
  logic result_full;
  logic rsp_full;

  logic we;
  logic [IdxW-1:0] waddr;
  desc_t wdata;
  desc_t rdata;

  logic accept;
  logic at_end;
  logic hit_alloc, hit_free;
  logic [SizeW-1:0] limit;
  logic can_carve;
  logic owner_bad;
  logic result_move;

  esba_desc_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOTAL_UNITS) ? {21'd0, total_units} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_units <= SizeW'(MaxUnits);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TOTAL_UNITS) begin
      total_units <= pwdata[SizeW-1:0];
    end
  end

  assign req_stall = (state != ST_IDLE) || result_full;
  assign accept = req_valid && !req_stall;
  assign owner_bad = 1'b0;  // 10-bit owner is never flagged as bad
  assign at_end = ({1'b0, idx} + 1'b1) >= block_count;
  assign hit_alloc = !rdata.in_use && rdata.length == cur.request_size;
  assign hit_free = rdata.in_use && rdata.owner == cur.owner_id;
  assign limit = (total_units > SizeW'(MaxUnits)) ? SizeW'(MaxUnits) : total_units;
  assign can_carve = (block_count < SizeW'(MaxUnits)) && (bump_pointer <= limit) &&
                     (cur.request_size <= limit - bump_pointer) && !owner_bad;
  assign result_move = result_full && (!rsp_full || !rsp_stall);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_READ;
      end
      ST_READ: begin
        if (cur.mode == MODE_ALLOC && cur.request_size == '0) state_next = ST_DONE;
        else if (block_count == '0)
          state_next = (cur.mode == MODE_ALLOC) ? ST_CARVE : ST_DONE;
        else state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (cur.mode == MODE_ALLOC && hit_alloc) state_next = ST_DONE;
        else if (at_end) state_next = (cur.mode == MODE_ALLOC) ? ST_CARVE : ST_DONE;
        else state_next = ST_READ;
      end
      ST_CARVE: state_next = ST_DONE;
      ST_DONE: begin
        if (!result_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table write
  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = rdata;
    case (state)
      ST_CHECK: begin
        if (cur.mode == MODE_ALLOC && hit_alloc) begin
          we = 1'b1;
          wdata.in_use = 1'b1;
          wdata.owner = cur.owner_id;
        end else if (cur.mode != MODE_ALLOC && hit_free) begin
          we = 1'b1;
          wdata.in_use = 1'b0;
        end
      end
      ST_CARVE: begin
        we = can_carve;
        waddr = block_count[IdxW-1:0];
        wdata.start = bump_pointer[IdxW-1:0];
        wdata.length = cur.request_size;
        wdata.owner = cur.owner_id;
        wdata.in_use = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      block_count <= '0;
      bump_pointer <= '0;
      result_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CARVE && can_carve) begin
        block_count <= block_count + 1'b1;
        bump_pointer <= bump_pointer + cur.request_size;
      end
      if (state == ST_DONE && !result_full) result_full <= 1'b1;
      else if (result_move) result_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
      idx <= '0;
      sum <= '0;
      result.block_address <= NO_ROOM;
      result.freed_units <= '0;
    end
    case (state)
      ST_READ: begin
        if (cur.mode != MODE_ALLOC) result.block_address <= '0;
      end
      ST_CHECK: begin
        idx <= idx + 1'b1;
        if (cur.mode == MODE_ALLOC && hit_alloc)
          result.block_address <= AddrW'({1'b0, rdata.start});
        if (cur.mode != MODE_ALLOC && hit_free) sum <= sum + rdata.length;
      end
      ST_CARVE: begin
        if (can_carve) result.block_address <= AddrW'(bump_pointer);
      end
      ST_DONE: begin
        if (cur.mode != MODE_ALLOC) result.freed_units <= sum;
      end
      default: ;
    endcase
  end

  // Output register: loads the finished result when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (result_move) begin
      rsp_full <= 1'b1;
    end else if (rsp_full && !rsp_stall) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_move) rsp <= result;
  end

  assign rsp_valid = rsp_full;

endmodule

>>> verif/esba_checker.sv
// Checker for the exact-size block allocator: tracks the block table and compares results.
module esba_checker
  import esba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          grants,
  output int          no_room,
  output int          frees
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the allocator state
  logic [10:0] unit_limit;
  logic [9:0]  blk_start [MaxUnits];
  logic [10:0] blk_len   [MaxUnits];
  logic [9:0]  blk_owner [MaxUnits];
  logic        blk_busy  [MaxUnits];
  int          blk_count;
  int          bump;
  rsp_t        expected_q[$];

  initial begin
    errors = 0;
    pending = 0;
    grants = 0;
    no_room = 0;
    frees = 0;
  end

  // Allocate: reuse the lowest free block of exactly this size, else carve at bump.
  function automatic logic signed [AddrW-1:0] grant_block(int size, logic [9:0] who);
    int lim;
    if (size == 0) return NO_ROOM;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_busy[i] && blk_len[i] == size) begin
        blk_busy[i] = 1'b1;
        blk_owner[i] = who;
        return {1'b0, blk_start[i]};
      end
    end
    lim = (unit_limit > MaxUnits) ? MaxUnits : unit_limit;
    if (blk_count >= MaxUnits || bump > lim || size > lim - bump) return NO_ROOM;
    blk_start[blk_count] = bump[9:0];
    blk_len[blk_count] = size[10:0];
    blk_owner[blk_count] = who;
    blk_busy[blk_count] = 1'b1;
    blk_count++;
    bump += size;
    return {1'b0, blk_start[blk_count-1]};
  endfunction

  // Free: release every block of the owner, sum wraps to the field width.
  function automatic logic [SizeW-1:0] release_owner(logic [9:0] who);
    int sum;
    sum = 0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_busy[i] && blk_owner[i] == who) begin
        blk_busy[i] = 1'b0;
        sum += blk_len[i];
      end
    end
    return sum[SizeW-1:0];
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t p;
    if (r.mode == MODE_ALLOC) begin
      p.block_address = grant_block(int'(r.request_size), r.owner_id);
      p.freed_units = '0;
    end else begin
      p.block_address = '0;
      p.freed_units = release_owner(r.owner_id);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      unit_limit = 11'd1024;
      blk_count = 0;
      bump = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TOTAL_UNITS)
        unit_limit = pwdata[10:0];
      if (req_valid && !req_stall) begin
        want = predict_result(req);
        expected_q.push_back(want);
        if (req.mode != MODE_ALLOC) frees++;
        else if (want.block_address == NO_ROOM) no_room++;
        else grants++;
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, address", int'(got.block_address), -2);
        end else begin
          want = expected_q.pop_front();
          if (got.block_address !== want.block_address)
            report_mismatch("block_address", int'(got.block_address),
                            int'(want.block_address));
          if (got.freed_units !== want.freed_units)
            report_mismatch("freed_units", int'(got.freed_units), int'(want.freed_units));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> verif/exact_size_block_allocator_tb.sv
// Testbench top for the exact-size block allocator: stimulus, watchdog and verdict.
module exact_size_block_allocator_tb;
  import esba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 30000;
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = ADDR_TOTAL_UNITS;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, grants, no_room, frees;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_ask = 1'b0;

  exact_size_block_allocator dut (.*);

  esba_checker checker_i (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .grants, .no_room, .frees
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: too long without any accepted request or result
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stall, or a long counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        rsp_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_ask = 1'b0;
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= !steady && ($urandom_range(99) < 33);
      end
    end
  end

  task automatic offer(input req_t r);
    if (!steady && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic offer_alloc(input int size, input int who);
    req_t r;
    r.mode = MODE_ALLOC;
    r.request_size = size[SizeW-1:0];
    r.owner_id = who[OwnW-1:0];
    offer(r);
  endtask

  task automatic offer_free(input int who);
    req_t r;
    r.mode = ~MODE_ALLOC;
    r.request_size = SizeW'($urandom_range(0, 2047));
    r.owner_id = who[OwnW-1:0];
    offer(r);
  endtask

  // Sender pause until every result is back, then let the block settle
  task automatic wait_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TOTAL_UNITS;
    pwdata <= {21'($urandom_range(0, 2097151)), value[10:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small sizes and a small owner pool so blocks get reused and freed
  task automatic random_requests(input int count, input bit pressure);
    int pick;
    int who;
    for (int n = 0; n < count; n++) begin
      steady = (n >= 40 && n < 110);
      if (pressure && n == 150) hold_ask = 1'b1;
      if (pressure && n == 200) wait_drain();
      who = ($urandom_range(99) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
      if ($urandom_range(99) < 20) begin
        offer_free(who);
      end else begin
        pick = $urandom_range(99);
        if (pick < 85) offer_alloc($urandom_range(1, 16), who);
        else if (pick < 95) offer_alloc($urandom_range(17, 128), who);
        else offer_alloc($urandom_range(0, 2047), who);
      end
    end
    steady = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny memory, zero size, exact fill, overflow, oversize, reuse
    write_limit(16);
    offer_alloc(0, 0);
    offer_alloc(16, 1023);
    offer_alloc(1, 1);
    offer_alloc(2047, 2);
    offer_alloc(1024, 3);
    offer_free(1023);
    offer_alloc(16, 0);
    offer_free(3);
    offer_free(0);
    offer_alloc(16, 682);
    offer_free(341);
    offer_free(682);
    wait_drain();

    // Limit above the memory size acts as the full memory
    write_limit(2047);
    random_requests(250, 1'b1);

    // Limit shrunk below the bump pointer: only reuse succeeds
    write_limit(1);
    random_requests(150, 1'b0);

    write_limit(1024);
    random_requests(180, 1'b0);

    $display("covered %0d grants, %0d no-room answers, %0d frees", grants, no_room, frees);
    $display("limits 16, 2047, 1 and 1024, with a long result hold-off and drain pauses");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
